### rtl/core/brsct_pkg.sv
// Shared constants, types and codes of the bitmap range set/clear/test block.
`default_nettype none

package brsct_pkg;

   // Bitmap geometry
   localparam int WORD_COUNT = 1024;
   localparam int WORD_W     = 32;
   localparam int BIT_IDX_W  = $clog2(WORD_W);
   localparam int ADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam logic [31:0] TOTAL_BITS = 32'(WORD_COUNT * WORD_W);
   localparam logic [WORD_W-1:0] ALL_ONES = '1;

   // Request field widths
   localparam int MODE_W  = 3;
   localparam int FIELD_W = 16;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Request modes
   typedef enum logic [MODE_W-1:0] {
      MODE_SET       = 3'd0,
      MODE_CLEAR     = 3'd1,
      MODE_ALL_ONES  = 3'd2,
      MODE_ANY_ONE   = 3'd3,
      MODE_ALL_ZEROS = 3'd4
   } mode_type;

   // Classified command handed from front to back
   typedef struct packed {
      logic                 skip;    // no memory work, result is known
      logic                 answer;  // result for a skipped command
      logic                 error;   // lower above upper
      mode_type             mode;
      logic [ADDR_W-1:0]    first;   // first word of the range
      logic [ADDR_W-1:0]    last;    // last word of the range
      logic [BIT_IDX_W-1:0] lo;      // first bit within the first word
      logic [BIT_IDX_W-1:0] hi_m1;   // last bit within the last word
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   // Back end sequencer states
   typedef enum logic [3:0] {
      ST_INIT  = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_RUN   = 4'b0100,
      ST_DRAIN = 4'b1000
   } state_type;

endpackage

`default_nettype wire

### rtl/core/brsct_if.sv
// Request and response channel interfaces of the bitmap range block.
`default_nettype none

interface brsct_req_if import brsct_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [MODE_W-1:0]  mode;
   logic [FIELD_W-1:0] lower;
   logic [FIELD_W-1:0] upper;

   modport source (output valid, output mode, output lower, output upper, input ready);
   modport sink   (input valid, input mode, input lower, input upper, output ready);
endinterface

interface brsct_rsp_if ();
   logic valid;
   logic ready;
   logic answer;
   logic error;

   modport source (output valid, output answer, output error, input ready);
   modport sink   (input valid, input answer, input error, output ready);
endinterface

`default_nettype wire

### rtl/core/brsct_ram.sv
// Generic simple dual-port RAM, one write and one registered read per cycle.
`default_nettype none

module brsct_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/core/brsct_front.sv
// Front end: takes request words, checks order, saturates and classifies them.
`default_nettype none

module brsct_front import brsct_pkg::*; (
   brsct_req_if.sink           req_port,
   input  wire logic           init_done,
   input  wire queue_stat_type q_stat,
   output logic                push,
   output cmd_type             push_cmd
);

   logic [31:0] lower_ext;
   logic [31:0] upper_ext;
   logic [31:0] lo_sat;
   logic [31:0] up_sat;
   logic [31:0] up_last;
   logic        bad_order;
   logic        valid_mode;
   logic        empty;

   // Take a word whenever the queue has room and the bitmap is cleared
   assign req_port.ready = init_done & ~q_stat.full;
   assign push           = req_port.valid & req_port.ready;

   // Range saturation and classification
   always_comb begin
      lower_ext  = 32'(req_port.lower);
      upper_ext  = 32'(req_port.upper);
      lo_sat     = (lower_ext > TOTAL_BITS) ? TOTAL_BITS : lower_ext;
      up_sat     = (upper_ext > TOTAL_BITS) ? TOTAL_BITS : upper_ext;
      up_last    = up_sat - 32'd1;
      bad_order  = (req_port.lower > req_port.upper);
      valid_mode = req_port.mode inside {[MODE_SET:MODE_ALL_ZEROS]};
      empty      = (lo_sat >= up_sat);

      push_cmd.error  = bad_order;
      push_cmd.skip   = bad_order | ~valid_mode | empty;
      // empty range: all-ones and all-zeros hold, any-one does not
      push_cmd.answer = ~bad_order & valid_mode & empty &
                        ((req_port.mode == MODE_ALL_ONES) ||
                         (req_port.mode == MODE_ALL_ZEROS));
      push_cmd.mode   = valid_mode ? mode_type'(req_port.mode) : MODE_SET;
      push_cmd.first  = lo_sat[BIT_IDX_W +: ADDR_W];
      push_cmd.last   = up_last[BIT_IDX_W +: ADDR_W];
      push_cmd.lo     = lo_sat[BIT_IDX_W-1:0];
      push_cmd.hi_m1  = up_last[BIT_IDX_W-1:0];
   end

endmodule

`default_nettype wire

### rtl/core/brsct_queue.sv
// Short command queue that decouples the front end from the back end.
`default_nettype none

module brsct_queue import brsct_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   input  wire logic    pop,
   output cmd_type      pop_cmd,
   output queue_stat_type q_stat
);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign pop_cmd        = entry_ff[rd_ptr_ff];
   assign q_stat.full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_stat.empty   = (count_ff == '0);

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

### rtl/core/brsct_back.sv
// Back end: clears the bitmap after reset and walks each range word by word.
`default_nettype none

module brsct_back import brsct_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire queue_stat_type q_stat,
   input  wire cmd_type        pop_cmd,
   output logic                pop,
   output logic                init_done,
   brsct_rsp_if.source         rsp_port
);

   state_type            state_ff, state_in;
   logic [ADDR_W-1:0]    clr_ff, clr_in;
   cmd_type              cur_ff, cur_in;
   logic [ADDR_W-1:0]    w_ff, w_in;
   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_last_ff, s1_last_in;
   logic [ADDR_W-1:0]    s1_addr_ff, s1_addr_in;
   logic [WORD_W-1:0]    s1_mask_ff, s1_mask_in;
   logic                 all_ff, all_in;
   logic                 any_ff, any_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_answer_ff, rsp_answer_in;
   logic                 rsp_error_ff, rsp_error_in;

   logic                 ram_wr_en;
   logic [ADDR_W-1:0]    ram_wr_addr;
   logic [WORD_W-1:0]    ram_wr_data;
   logic [WORD_W-1:0]    ram_rd_data;

   logic [BIT_IDX_W-1:0] lo_cur;
   logic [BIT_IDX_W-1:0] hi_cur;
   logic [WORD_W-1:0]    mask_cur;
   logic [WORD_W-1:0]    masked;
   logic                 all_now;
   logic                 any_now;

   brsct_ram #(
      .WIDTH (WORD_W),
      .DEPTH (WORD_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (w_ff),
      .rd_data (ram_rd_data)
   );

   assign init_done       = (state_ff != ST_INIT);
   assign rsp_port.valid  = rsp_valid_ff;
   assign rsp_port.answer = rsp_answer_ff;
   assign rsp_port.error  = rsp_error_ff;

   // Edge mask of the word being read
   always_comb begin
      lo_cur   = (w_ff == cur_ff.first) ? cur_ff.lo : '0;
      hi_cur   = (w_ff == cur_ff.last) ? cur_ff.hi_m1 : '1;
      mask_cur = (ALL_ONES << lo_cur) & (ALL_ONES >> (BIT_IDX_W'(WORD_W - 1) - hi_cur));
   end

   // Word returned by the RAM against its mask
   always_comb begin
      masked  = ram_rd_data & s1_mask_ff;
      all_now = all_ff & (masked == s1_mask_ff);
      any_now = any_ff | (masked != '0);
   end

   // Write port: clearing sweep, then read-modify-write of set and clear
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = s1_addr_ff;
      ram_wr_data = ram_rd_data | s1_mask_ff;
      if (state_ff == ST_INIT) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_ff;
         ram_wr_data = '0;
      end else if (s1_valid_ff) begin
         case (cur_ff.mode)
            MODE_SET: begin
               ram_wr_en   = 1'b1;
               ram_wr_data = ram_rd_data | s1_mask_ff;
            end
            MODE_CLEAR: begin
               ram_wr_en   = 1'b1;
               ram_wr_data = ram_rd_data & ~s1_mask_ff;
            end
            default: begin
               ram_wr_en = 1'b0;
            end
         endcase
      end
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      cur_in        = cur_ff;
      w_in          = w_ff;
      s1_valid_in   = 1'b0;
      s1_last_in    = 1'b0;
      s1_addr_in    = w_ff;
      s1_mask_in    = mask_cur;
      all_in        = all_ff;
      any_in        = any_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_answer_in = rsp_answer_ff;
      rsp_error_in  = rsp_error_ff;
      pop           = 1'b0;

      if (rsp_valid_ff && rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_INIT: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(WORD_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            // start only with an empty result slot, so the result never waits
            if (!q_stat.empty && !rsp_valid_ff) begin
               pop = 1'b1;
               if (pop_cmd.skip) begin
                  rsp_valid_in  = 1'b1;
                  rsp_answer_in = pop_cmd.answer;
                  rsp_error_in  = pop_cmd.error;
               end else begin
                  cur_in   = pop_cmd;
                  w_in     = pop_cmd.first;
                  all_in   = 1'b1;
                  any_in   = 1'b0;
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            s1_valid_in = 1'b1;
            s1_last_in  = (w_ff == cur_ff.last);
            if (w_ff == cur_ff.last) begin
               state_in = ST_DRAIN;
            end else begin
               w_in = w_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DRAIN;
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase

      // Fold in the returned word; the last one finishes the command
      if (s1_valid_ff) begin
         all_in = all_now;
         any_in = any_now;
         if (s1_last_ff) begin
            rsp_valid_in = 1'b1;
            rsp_error_in = 1'b0;
            case (cur_ff.mode)
               MODE_ALL_ONES:  rsp_answer_in = all_now;
               MODE_ANY_ONE:   rsp_answer_in = any_now;
               MODE_ALL_ZEROS: rsp_answer_in = ~any_now;
               default:        rsp_answer_in = 1'b0;
            endcase
            state_in = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         clr_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      w_ff          <= w_in;
      s1_last_ff    <= s1_last_in;
      s1_addr_ff    <= s1_addr_in;
      s1_mask_ff    <= s1_mask_in;
      all_ff        <= all_in;
      any_ff        <= any_in;
      rsp_answer_ff <= rsp_answer_in;
      rsp_error_ff  <= rsp_error_in;
   end

endmodule

`default_nettype wire

### rtl/core/bitmap_range_set_clear_test.sv
// Top level of the bitmap range set/clear/test block.
//
//   Channel    Direction  Carries
//   req_port   in         mode, lower, upper
//   rsp_port   out        answer, error
//
// A range spanning N memory words holds the back end while it picks the
// command from the queue, reads each word from the RAM and finishes the last
// read-modify-write. The result shows in the cycle after that. A new command
// starts only once the result register is empty, in the cycle after the
// result is taken, so the back end holds one command at a time.
// Error, unused-mode and empty-range words are answered from the pick cycle
// alone, with no RAM access.
// After reset the bitmap is swept to zero, one word a cycle;
// req_port.ready stays low for that time.
// A two-entry queue keeps taking request words while a result is held.
`default_nettype none

module bitmap_range_set_clear_test import brsct_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   brsct_req_if.sink   req_port,
   brsct_rsp_if.source rsp_port
);

   logic           push;
   cmd_type        push_cmd;
   logic           pop;
   cmd_type        pop_cmd;
   queue_stat_type q_stat;
   logic           init_done;

   brsct_front u_front (
      .req_port  (req_port),
      .init_done (init_done),
      .q_stat    (q_stat),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   brsct_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .q_stat   (q_stat)
   );

   brsct_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .pop_cmd   (pop_cmd),
      .pop       (pop),
      .init_done (init_done),
      .rsp_port  (rsp_port)
   );

endmodule

`default_nettype wire

### rtl/core/brsct_checker.sv
// Port-level checks of the bitmap range block, bound to the top level.
`default_nettype none

module brsct_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_answer,
   input wire logic rsp_error
);

   logic [2:0] pend_ff, pend_in;

   // Words taken but not yet answered
   always_comb begin
      pend_in = pend_ff;
      if ((req_valid && req_ready) && !(rsp_valid && rsp_ready)) begin
         pend_in = pend_ff + 3'd1;
      end else if (!(req_valid && req_ready) && (rsp_valid && rsp_ready)) begin
         pend_in = pend_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // Clearing sweep follows reset: nothing taken, nothing offered
   a_sweep_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready && !rsp_valid)
      else $error("request taken or result offered during the clearing sweep");

   a_error_no_answer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> !rsp_answer)
      else $error("error result carries a true answer");

   a_no_unsolicited: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 3'd0)
      else $error("result offered with no request outstanding");

   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= 3'd3)
      else $error("more requests outstanding than queue and back end hold");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_answer) && $stable(rsp_error))
      else $error("stalled result dropped or changed");

endmodule

bind bitmap_range_set_clear_test brsct_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_port.valid),
   .req_ready  (req_port.ready),
   .rsp_valid  (rsp_port.valid),
   .rsp_ready  (rsp_port.ready),
   .rsp_answer (rsp_port.answer),
   .rsp_error  (rsp_port.error)
);

`default_nettype wire
